// ===== design/drq_pkg.sv =====
package drq_pkg;

    typedef struct packed {
        logic       cmd;
        logic [7:0] item_in;
    } t_cmd_beat;

    typedef struct packed {
        logic [7:0] item_out;
        logic [1:0] status;
        logic       replaced;
        logic [4:0] count;
    } t_res_beat;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_GET,
        ST_SCAN
    } t_state;

    localparam logic CMD_PUT = 1'b0;
    localparam logic CMD_GET = 1'b1;

    localparam logic [1:0] STS_OK    = 2'd0;
    localparam logic [1:0] STS_EMPTY = 2'd1;
    localparam logic [1:0] STS_FULL  = 2'd2;

endpackage

// ===== design/dedup_recency_queue.sv =====
// Channel | Ports                     | Handshake
// --------+---------------------------+-------------------------------------
// command | i_cmd (cmd, item_in)      | taken when i_start high, o_busy low
// result  | o_res (item_out, status,  | valid for one cycle with o_done;
//         |        replaced, count)   | no back-pressure
//
// Entries sit in a circular buffer in one RAM with a registered read.
// A get reads the oldest entry, then returns it; a put into an empty queue or a
// failing get ends at the accept. Other puts take the accept, one RAM read per
// entry to search and close the gap, one for the last read, then the write.
// Synchronous reset empties the queue; RAM contents are left as they are.
// Results are registered out of the last step and cannot be stalled.
module dedup_recency_queue #(
    parameter int DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  drq_pkg::t_cmd_beat i_cmd,
    output logic               o_busy,
    output logic               o_done,
    output drq_pkg::t_res_beat o_res
);
    import drq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_state        r_state, n_state;
    logic [AW-1:0] r_head, n_head;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_rptr, n_rptr;
    logic [AW-1:0] r_src, n_src;
    logic [AW-1:0] r_dst, n_dst;
    logic [CW-1:0] r_idx, n_idx;
    logic          r_dv, n_dv;
    logic          r_found, n_found;
    logic [7:0]    r_item, n_item;
    logic          r_done, n_done;
    t_res_beat     r_res, n_res;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [7:0]    mem_rdata;
    logic          scan_end;

    function automatic logic [AW-1:0] f_inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [4:0] f_cnt5(input logic [CW-1:0] c);
        logic [CW+4:0] w;
        w = {5'b0, c};
        return w[4:0];
    endfunction

    drq_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign scan_end = !r_dv && (r_idx == r_count);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start && r_count != '0) begin
                    n_state = (i_cmd.cmd == CMD_GET) ? ST_GET : ST_SCAN;
                end
            end
            ST_GET: begin
                n_state = ST_IDLE;
            end
            ST_SCAN: begin
                if (scan_end) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_head    = r_head;
        n_count   = r_count;
        n_rptr    = r_rptr;
        n_src     = r_src;
        n_dst     = r_dst;
        n_idx     = r_idx;
        n_dv      = 1'b0;
        n_found   = r_found;
        n_item    = r_item;
        n_done    = 1'b0;
        n_res     = r_res;
        mem_we    = 1'b0;
        mem_waddr = r_dst;
        mem_wdata = r_item;
        mem_raddr = r_rptr;
        unique case (r_state)
            ST_IDLE: begin
                mem_raddr = r_head;
                if (i_start) begin
                    n_item = i_cmd.item_in;
                    if (i_cmd.cmd == CMD_GET) begin
                        if (r_count == '0) begin
                            n_done = 1'b1;
                            n_res  = '{item_out: 8'd0, status: STS_EMPTY, replaced: 1'b0,
                                       count: f_cnt5(r_count)};
                        end
                    end else if (r_count == '0) begin
                        mem_we    = 1'b1;
                        mem_waddr = r_head;
                        mem_wdata = i_cmd.item_in;
                        n_count   = CW'(1);
                        n_done    = 1'b1;
                        n_res     = '{item_out: 8'd0, status: STS_OK, replaced: 1'b0,
                                      count: f_cnt5(CW'(1))};
                    end else begin
                        n_rptr  = r_head;
                        n_idx   = '0;
                        n_found = 1'b0;
                    end
                end
            end
            ST_GET: begin
                n_head  = f_inc(r_head);
                n_count = r_count - 1'b1;
                n_done  = 1'b1;
                n_res   = '{item_out: mem_rdata, status: STS_OK, replaced: 1'b0,
                            count: f_cnt5(r_count - 1'b1)};
            end
            ST_SCAN: begin
                if (r_idx != r_count) begin
                    n_src  = r_rptr;
                    n_rptr = f_inc(r_rptr);
                    n_idx  = r_idx + 1'b1;
                    n_dv   = 1'b1;
                end
                if (r_dv) begin
                    if (r_found) begin
                        mem_we    = 1'b1;
                        mem_waddr = r_dst;
                        mem_wdata = mem_rdata;
                        n_dst     = r_src;
                    end else if (mem_rdata == r_item) begin
                        n_found = 1'b1;
                        n_dst   = r_src;
                    end
                end
                if (scan_end) begin
                    n_done = 1'b1;
                    if (r_found) begin
                        mem_we    = 1'b1;
                        mem_waddr = r_dst;
                        n_res     = '{item_out: 8'd0, status: STS_OK, replaced: 1'b1,
                                      count: f_cnt5(r_count)};
                    end else if (r_count != CW'(DEPTH)) begin
                        mem_we    = 1'b1;
                        mem_waddr = r_rptr;
                        n_count   = r_count + 1'b1;
                        n_res     = '{item_out: 8'd0, status: STS_OK, replaced: 1'b0,
                                      count: f_cnt5(r_count + 1'b1)};
                    end else begin
                        n_res     = '{item_out: 8'd0, status: STS_FULL, replaced: 1'b0,
                                      count: f_cnt5(r_count)};
                    end
                end
            end
            default: begin
                n_dv = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_head  <= '0;
            r_count <= '0;
            r_dv    <= 1'b0;
            r_found <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
            r_dv    <= n_dv;
            r_found <= n_found;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rptr <= n_rptr;
        r_src  <= n_src;
        r_dst  <= n_dst;
        r_idx  <= n_idx;
        r_item <= n_item;
        r_res  <= n_res;
    end

    assign o_busy = (r_state != ST_IDLE);
    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

// ===== design/drq_ram.sv =====
module drq_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== verif/dedup_recency_queue_tb.sv =====
module dedup_recency_queue_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import drq_pkg::*;

    localparam int DEPTH      = 16;
    localparam int N_RANDOM   = 1000;
    localparam int CYCLE_CAP  = 400000;
    localparam int DRAIN_WAIT = 40;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_start = 1'b0;
    t_cmd_beat i_cmd   = '0;
    logic      o_busy;
    logic      o_done;
    t_res_beat o_res;

    t_cmd_beat  cmd_beats[$];
    t_res_beat  res_expect[$];
    logic [7:0] held_items[DEPTH];
    int         held_cnt     = 0;
    int         issued_cnt   = 0;
    int         mismatch_cnt = 0;
    int         cycle_cnt    = 0;
    bit         beat_taken   = 1'b0;

    dedup_recency_queue #(
        .DEPTH (DEPTH)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_cmd   (i_cmd),
        .o_busy  (o_busy),
        .o_done  (o_done),
        .o_res   (o_res)
    );

    always #10 i_clk = ~i_clk;

    function automatic t_res_beat next_result(t_cmd_beat b);
        t_res_beat r;
        int        pos;
        int        i;
        r   = '0;
        pos = -1;
        if (b.cmd == CMD_PUT) begin
            for (i = 0; i < held_cnt; i++) begin
                if (pos < 0 && held_items[i] == b.item_in) begin
                    pos = i;
                end
            end
            if (pos >= 0) begin
                for (i = pos; i < held_cnt - 1; i++) begin
                    held_items[i] = held_items[i + 1];
                end
                held_items[held_cnt - 1] = b.item_in;
                r.replaced = 1'b1;
            end else if (held_cnt < DEPTH) begin
                held_items[held_cnt] = b.item_in;
                held_cnt++;
            end else begin
                r.status = STS_FULL;
            end
        end else begin
            if (held_cnt == 0) begin
                r.status = STS_EMPTY;
            end else begin
                r.item_out = held_items[0];
                for (i = 0; i < held_cnt - 1; i++) begin
                    held_items[i] = held_items[i + 1];
                end
                held_cnt--;
            end
        end
        r.count = 5'(held_cnt);
        return r;
    endfunction

    function automatic t_cmd_beat make_beat(logic cmd, logic [7:0] item);
        t_cmd_beat b;
        b.cmd     = cmd;
        b.item_in = item;
        return b;
    endfunction

    // hold the beat until taken
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_start || beat_taken)) begin
            if (cmd_beats.size() > 0 &&
                ((issued_cnt >= 400 && issued_cnt < 600) || $urandom_range(0, 99) >= 37)) begin
                i_start <= 1'b1;
                i_cmd   <= cmd_beats.pop_front();
                issued_cnt++;
            end else begin
                i_start <= 1'b0;
                i_cmd   <= t_cmd_beat'($urandom);
            end
        end
    end

    always @(posedge i_clk) begin
        t_res_beat exp_res;
        beat_taken = i_rst_n && i_start && !o_busy;
        if (beat_taken) begin
            res_expect.push_back(next_result(i_cmd));
        end
        if (i_rst_n && o_done) begin
            if (res_expect.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %p", $time, o_res);
                mismatch_cnt++;
            end else begin
                exp_res = res_expect.pop_front();
                if (o_res.item_out !== exp_res.item_out) begin
                    $display("%0t: item_out expected %0d actual %0d",
                             $time, exp_res.item_out, o_res.item_out);
                    mismatch_cnt++;
                end
                if (o_res.status !== exp_res.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, exp_res.status, o_res.status);
                    mismatch_cnt++;
                end
                if (o_res.replaced !== exp_res.replaced) begin
                    $display("%0t: replaced expected %0d actual %0d",
                             $time, exp_res.replaced, o_res.replaced);
                    mismatch_cnt++;
                end
                if (o_res.count !== exp_res.count) begin
                    $display("%0t: count expected %0d actual %0d",
                             $time, exp_res.count, o_res.count);
                    mismatch_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_CAP) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        int         n;
        int         k;
        int         run_len;
        int         put_pct;
        int         span;
        logic [7:0] base;
        logic       cmd;

        // directed: empty get, single-entry replace, replace, fill, full reject,
        // replace while full, get of the oldest
        cmd_beats.push_back(make_beat(CMD_GET, 8'hA5));
        cmd_beats.push_back(make_beat(CMD_PUT, 8'h5A));
        cmd_beats.push_back(make_beat(CMD_PUT, 8'h5A));
        cmd_beats.push_back(make_beat(CMD_PUT, 8'h00));
        cmd_beats.push_back(make_beat(CMD_PUT, 8'hFF));
        cmd_beats.push_back(make_beat(CMD_PUT, 8'h00));
        for (k = 1; k <= 13; k++) begin
            cmd_beats.push_back(make_beat(CMD_PUT, 8'(k * 17)));
        end
        cmd_beats.push_back(make_beat(CMD_PUT, 8'h80));
        cmd_beats.push_back(make_beat(CMD_PUT, 8'h5A));
        cmd_beats.push_back(make_beat(CMD_GET, 8'h00));

        n = 0;
        while (n < N_RANDOM) begin
            case ($urandom_range(0, 3))
                0: put_pct = 20;
                1: put_pct = 50;
                2: put_pct = 75;
                default: put_pct = 95;
            endcase
            case ($urandom_range(0, 3))
                0: span = 3;
                1: span = 15;
                2: span = 31;
                default: span = 255;
            endcase
            base    = 8'($urandom_range(0, 255));
            run_len = $urandom_range(20, 60);
            for (k = 0; k < run_len && n < N_RANDOM; k++) begin
                cmd = ($urandom_range(0, 99) < put_pct) ? CMD_PUT : CMD_GET;
                cmd_beats.push_back(make_beat(cmd, base ^ 8'($urandom_range(0, span))));
                n++;
            end
        end

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_beats.size() != 0 || i_start || res_expect.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (mismatch_cnt == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/drq_pkg.sv
design/drq_ram.sv
design/dedup_recency_queue.sv
verif/dedup_recency_queue_tb.sv
